[sv/mwebr_pkg.sv]
package mwebr_pkg;

	// Default number of bytes in the store.
	localparam int unsigned DEPTH_DEF = 2048;

	// Width of the size register and its value after reset.
	localparam int unsigned SIZE_W = 12;
	localparam logic [SIZE_W-1:0] MEM_SIZE_RST = 12'd2048;

	// Operation codes of the kind field.
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// Access size codes.
	localparam logic [1:0] WCODE_BYTE = 2'd0;
	localparam logic [1:0] WCODE_HALF = 2'd1;
	localparam logic [1:0] WCODE_WORD = 2'd2;
	localparam logic [1:0] WCODE_RSVD = 2'd3;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ACCESS,
		ST_DRAIN,
		ST_CLEAR,
		ST_DONE
	} state_t;

	// One byte access toward the store. The address is wide enough for
	// the largest store; the store uses only the bits it needs.
	typedef struct packed {
		logic        en;
		logic        we;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} mem_req_t;

	// One finished result.
	typedef struct packed {
		logic [31:0] read_data;
		logic        range_error;
	} res_t;

endpackage

[sv/mwebr_req_if.sv]
interface mwebr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] address;
	logic [1:0]  width_code;
	logic        big_endian;
	logic [31:0] write_data;

	modport source (output valid, kind, address, width_code, big_endian, write_data,
		input ready);
	modport sink (input valid, kind, address, width_code, big_endian, write_data,
		output ready);
endinterface

[sv/mwebr_rsp_if.sv]
interface mwebr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        range_error;

	modport source (output valid, read_data, range_error, input ready);
	modport sink (input valid, read_data, range_error, output ready);
endinterface

[sv/mwebr_cfg_if.sv]
interface mwebr_cfg_if;
	logic        valid;
	logic        ready;
	logic [11:0] mem_size;

	modport source (output valid, mem_size, input ready);
	modport sink (input valid, mem_size, output ready);
endinterface

[sv/mwebr_ram.sv]
module mwebr_ram #(
	parameter int unsigned DEPTH = mwebr_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  mwebr_pkg::mem_req_t mem_req,
	output logic [7:0]          rdata
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] mem [DEPTH];

	// Single port byte store: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_req.en) begin
			if (mem_req.we) begin
				mem[mem_req.addr[AW-1:0]] <= mem_req.wdata;
			end else begin
				rdata <= mem[mem_req.addr[AW-1:0]];
			end
		end
	end

endmodule

[sv/mwebr_seq.sv]
module mwebr_seq #(
	parameter int unsigned DEPTH = mwebr_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mwebr_req_if.sink                     req,
	input  logic [mwebr_pkg::SIZE_W-1:0]  mem_size,
	output logic                          res_valid,
	output mwebr_pkg::res_t               res,
	input  logic                          res_ready,
	output mwebr_pkg::mem_req_t           mem_req,
	input  logic [7:0]                    mem_rdata
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [16:0] DEPTH_W = 17'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	mwebr_pkg::state_t state_q, state_d;

	logic [1:0]    kind_q;
	logic [15:0]   addr_q;
	logic [1:0]    wcode_q;
	logic          big_q;
	logic [31:0]   wdata_q;
	logic [1:0]    nm1_q;
	logic [1:0]    idx_q;
	logic [AW-1:0] clr_q;
	logic          err_q;
	logic [31:0]   rdata_q;
	logic          rd_pend_q;
	logic [1:0]    rd_pos_q;

	logic [15:0]   opa;
	logic [2:0]    opb;
	logic [16:0]   sum;
	logic [16:0]   size_use;
	logic [1:0]    pos;
	logic          accept;

	assign accept = req.valid && req.ready;

	// Size in use is the register, capped at the store depth.
	assign size_use = (17'(mem_size) > DEPTH_W) ? DEPTH_W : 17'(mem_size);

	// Byte position inside the word for the current step.
	assign pos = big_q ? (idx_q ^ nm1_q) : idx_q;

	// Shared adder: end of access in the check step, byte address in the
	// access steps, next address in the clear sweep.
	always_comb begin
		opa = addr_q;
		opb = 3'd0;
		unique case (state_q)
			mwebr_pkg::ST_CHECK: opb = {1'b0, nm1_q} + 3'd1;
			mwebr_pkg::ST_ACCESS: opb = {1'b0, idx_q};
			mwebr_pkg::ST_CLEAR: begin
				opa = 16'(clr_q);
				opb = 3'd1;
			end
			default: opb = 3'd0;
		endcase
	end
	assign sum = {1'b0, opa} + 17'(opb);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mwebr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, store requests and handshake outputs.
	always_comb begin
		state_d = state_q;
		req.ready = 1'b0;
		res_valid = 1'b0;
		mem_req = '0;
		unique case (state_q)
			mwebr_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.kind == mwebr_pkg::KIND_CLEAR) begin
						state_d = mwebr_pkg::ST_CLEAR;
					end else if (req.kind == mwebr_pkg::KIND_NONE) begin
						state_d = mwebr_pkg::ST_DONE;
					end else begin
						state_d = mwebr_pkg::ST_CHECK;
					end
				end
			end
			mwebr_pkg::ST_CHECK: begin
				if (wcode_q == mwebr_pkg::WCODE_RSVD || sum > size_use) begin
					state_d = mwebr_pkg::ST_DONE;
				end else begin
					state_d = mwebr_pkg::ST_ACCESS;
				end
			end
			mwebr_pkg::ST_ACCESS: begin
				mem_req.en = 1'b1;
				mem_req.we = (kind_q == mwebr_pkg::KIND_WRITE);
				mem_req.addr = sum[15:0];
				mem_req.wdata = wdata_q[8*pos +: 8];
				if (idx_q == nm1_q) begin
					state_d = mwebr_pkg::ST_DRAIN;
				end
			end
			mwebr_pkg::ST_DRAIN: begin
				state_d = mwebr_pkg::ST_DONE;
			end
			mwebr_pkg::ST_CLEAR: begin
				mem_req.en = 1'b1;
				mem_req.we = 1'b1;
				mem_req.addr = 16'(clr_q);
				mem_req.wdata = wdata_q[7:0];
				if (clr_q == LAST_IDX) begin
					state_d = mwebr_pkg::ST_DONE;
				end
			end
			mwebr_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = mwebr_pkg::ST_IDLE;
				end
			end
			default: state_d = mwebr_pkg::ST_IDLE;
		endcase
	end

	// Control flags of the running word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= (state_q == mwebr_pkg::ST_ACCESS) && (kind_q == mwebr_pkg::KIND_READ);
		end
	end

	// Word fields, step counters and read assembly.
	always_ff @(posedge clk) begin
		rd_pos_q <= pos;
		if (accept) begin
			kind_q <= req.kind;
			addr_q <= req.address;
			wcode_q <= req.width_code;
			big_q <= req.big_endian;
			wdata_q <= req.write_data;
			idx_q <= 2'd0;
			clr_q <= '0;
			err_q <= 1'b0;
			rdata_q <= '0;
			unique case (req.width_code)
				mwebr_pkg::WCODE_BYTE: nm1_q <= 2'd0;
				mwebr_pkg::WCODE_HALF: nm1_q <= 2'd1;
				default: nm1_q <= 2'd3;
			endcase
		end else begin
			if (state_q == mwebr_pkg::ST_CHECK) begin
				err_q <= (wcode_q == mwebr_pkg::WCODE_RSVD) || (sum > size_use);
			end
			if (state_q == mwebr_pkg::ST_ACCESS) begin
				idx_q <= idx_q + 2'd1;
			end
			if (state_q == mwebr_pkg::ST_CLEAR) begin
				clr_q <= sum[AW-1:0];
			end
			if (rd_pend_q) begin
				rdata_q[8*rd_pos_q +: 8] <= mem_rdata;
			end
		end
	end

	assign res.read_data = rdata_q;
	assign res.range_error = err_q;

endmodule

[sv/multi_width_endian_byte_ram_top.sv]
// Byte-addressed RAM with 1, 2 or 4 byte accesses in either byte order.
// Channels: req takes one word per operation (read, write or clear), rsp
// returns one word per operation with the read value and the range error
// flag, cfg writes the size in use (mem_size) and is always ready.
// A read or write of n bytes passes a check step, n access steps and a drain
// step; a range error ends after the check step, the unused kind goes straight
// to the result, and a clear sweeps every address once. The single port byte
// store moves one byte per cycle. A new word is taken in the cycle after the
// previous one has been handed to the output register, so the block takes no
// new word before it is through with the last one.
// The output register holds a finished result while rsp stalls, and the
// next word may be accepted and worked on meanwhile.
// Reset sets mem_size to 2048 and empties the pipeline; the store keeps
// no reset value and must be written or cleared before it is read.
module multi_width_endian_byte_ram_top #(
	parameter int unsigned DEPTH = mwebr_pkg::DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mwebr_req_if.sink  req,
	mwebr_rsp_if.source rsp,
	mwebr_cfg_if.sink  cfg
);

	logic [mwebr_pkg::SIZE_W-1:0] mem_size_q;
	mwebr_pkg::mem_req_t          mem_req;
	logic [7:0]                   mem_rdata;
	logic                         res_valid;
	logic                         res_ready;
	mwebr_pkg::res_t              res;
	logic                         out_valid_q;
	mwebr_pkg::res_t              out_q;

	// Size register.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= mwebr_pkg::MEM_SIZE_RST;
		end else if (cfg.valid) begin
			mem_size_q <= cfg.mem_size;
		end
	end

	mwebr_seq #(.DEPTH(DEPTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_size  (mem_size_q),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	mwebr_ram #(.DEPTH(DEPTH)) u_ram (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata   (mem_rdata)
	);

	// Output register: loads when empty or when its word leaves.
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.read_data = out_q.read_data;
	assign rsp.range_error = out_q.range_error;

endmodule

[test/mwebr_checker.sv]
`timescale 1ns / 100ps

// Watches the three channels, keeps its own image of the byte store and the
// size register, and compares every returned word with the oldest prediction.
module mwebr_checker #(
	parameter int unsigned DEPTH = mwebr_pkg::DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mwebr_req_if req,
	mwebr_rsp_if rsp,
	mwebr_cfg_if cfg,
	output int   mismatch_count,
	output int   outstanding
);
	import mwebr_pkg::*;

	logic [7:0]        ram_image [DEPTH];
	logic [SIZE_W-1:0] size_mirror;
	res_t              due_results [$];
	int                fault_total;

	// Apply one operation to the store image and return the word it must produce.
	function automatic res_t access_result(input logic [1:0] kind, input logic [15:0] addr,
		input logic [1:0] wcode, input logic big, input logic [31:0] wdata);
		res_t        r;
		int unsigned nbytes;
		int unsigned span;
		int unsigned base;
		int unsigned pos;
		r = '0;
		span = (size_mirror > DEPTH) ? DEPTH : size_mirror;
		base = addr;
		case (kind)
			KIND_CLEAR: begin
				for (int i = 0; i < DEPTH; i++)
					ram_image[i] = wdata[7:0];
			end
			KIND_READ, KIND_WRITE: begin
				case (wcode)
					WCODE_BYTE: nbytes = 1;
					WCODE_HALF: nbytes = 2;
					default:    nbytes = 4;
				endcase
				if (wcode == WCODE_RSVD || base + nbytes > span) begin
					r.range_error = 1'b1;
				end else if (kind == KIND_READ) begin
					// The lowest address lands in the low byte unless big endian.
					for (int unsigned i = 0; i < nbytes; i++) begin
						pos = big ? nbytes - 1 - i : i;
						r.read_data[8*pos +: 8] = ram_image[base + i];
					end
				end else begin
					for (int unsigned i = 0; i < nbytes; i++)
						ram_image[big ? base + nbytes - 1 - i : base + i] = wdata[8*i +: 8];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Track configuration, predict on each accepted request, check each result.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			size_mirror = MEM_SIZE_RST;
			due_results.delete();
			fault_total = 0;
			outstanding <= 0;
			mismatch_count <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				size_mirror = cfg.mem_size;
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected word, expected none, got read_data %08h range_error %0b",
						$time, rsp.read_data, rsp.range_error);
					fault_total++;
				end else begin
					want = due_results.pop_front();
					if (rsp.read_data !== want.read_data) begin
						$display("%0t: read_data expected %08h, got %08h",
							$time, want.read_data, rsp.read_data);
						fault_total++;
					end
					if (rsp.range_error !== want.range_error) begin
						$display("%0t: range_error expected %0b, got %0b",
							$time, want.range_error, rsp.range_error);
						fault_total++;
					end
				end
			end
			if (req.valid && req.ready)
				due_results.push_back(access_result(req.kind, req.address, req.width_code,
					req.big_endian, req.write_data));
			outstanding <= due_results.size();
			mismatch_count <= fault_total;
		end
	end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
	import mwebr_pkg::*;

	localparam int unsigned DEPTH = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_COUNT = 10;
	localparam int PHASE_WORDS = 143;

	logic        clk;
	logic        arst_n;
	logic        quiet;
	int          stall_left;
	int          cycle_count = 0;
	int          mismatch_count;
	int          outstanding;
	logic [11:0] size_now;
	logic [15:0] hot_base;

	mwebr_req_if req_ch ();
	mwebr_rsp_if rsp_ch ();
	mwebr_cfg_if cfg_ch ();

	multi_width_endian_byte_ram_top #(.DEPTH(DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	mwebr_checker #(.DEPTH(DEPTH)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.cfg            (cfg_ch),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The result side stalls in short random bursts, except near the end.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (quiet) begin
			rsp_ch.ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Offer one request word, with an optional idle burst first, and return
	// once it has been taken. Valid stays high for a following word.
	task automatic send_op(input logic [1:0] kind, input logic [15:0] addr,
		input logic [1:0] wcode, input logic big, input logic [31:0] wdata);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.address <= addr;
		req_ch.width_code <= wcode;
		req_ch.big_endian <= big;
		req_ch.write_data <= wdata;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Stop sending and wait until every predicted word has come back.
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Change the size in use while the block is idle.
	task automatic set_mem_size(input logic [11:0] value);
		int unsigned span;
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.mem_size <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		size_now = value;
		span = (value > DEPTH) ? DEPTH : value;
		hot_base = (span > 16) ? 16'($urandom_range(0, span - 16)) : 16'd0;
	endtask

	// Mostly reads and writes, anywhere, near the top of the size in use or in a
	// small window so that written bytes are read back; rare clears and unused kinds.
	task automatic random_op();
		logic [1:0]  width_pick [3];
		logic [1:0]  kind;
		logic [1:0]  wcode;
		logic [15:0] addr;
		int unsigned span;
		int unsigned nbytes;
		int unsigned pick;
		int          boundary_addr;
		int          jitter;
		width_pick = '{WCODE_BYTE, WCODE_HALF, WCODE_WORD};
		span = (size_now > DEPTH) ? DEPTH : size_now;
		if ($urandom_range(0, 63) == 0)
			kind = KIND_CLEAR;
		else if ($urandom_range(0, 49) == 0)
			kind = KIND_NONE;
		else
			kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
		wcode = ($urandom_range(0, 19) == 0) ? WCODE_RSVD : width_pick[$urandom_range(0, 2)];
		case (wcode)
			WCODE_BYTE: nbytes = 1;
			WCODE_HALF: nbytes = 2;
			default:    nbytes = 4;
		endcase
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			addr = 16'($urandom);
		end else if (pick <= 2) begin
			jitter = $urandom_range(0, 3);
			boundary_addr = int'(span) - int'(nbytes) - 1 + jitter;
			addr = (boundary_addr < 0) ? 16'd0 : 16'(boundary_addr);
		end else if (pick <= 5) begin
			addr = hot_base + 16'($urandom_range(0, 15));
		end else begin
			addr = (span == 0) ? 16'd0 : 16'($urandom_range(0, span - 1));
		end
		send_op(kind, addr, wcode, 1'($urandom_range(0, 1)), $urandom);
	endtask

	initial begin
		logic [11:0] phase_sizes [PHASE_COUNT];
		phase_sizes = '{12'd2048, 12'd1, 12'd0, 12'd4095, 12'd2, 12'd5, 12'd2047,
			12'd0, 12'd0, 12'd2048};
		phase_sizes[7] = 12'($urandom_range(1, 2048));
		phase_sizes[8] = 12'($urandom_range(0, 4095));

		arst_n <= 1'b0;
		quiet <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_READ;
		req_ch.address <= '0;
		req_ch.width_code <= WCODE_BYTE;
		req_ch.big_endian <= 1'b0;
		req_ch.write_data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.mem_size <= MEM_SIZE_RST;
		size_now = MEM_SIZE_RST;
		hot_base = 16'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the store first so that every later read sees written bytes.
		// The clear must ignore address, width and byte order.
		send_op(KIND_CLEAR, 16'hFFFF, WCODE_RSVD, 1'b1, 32'h0000_00A5);
		send_op(KIND_READ, 16'd0, WCODE_WORD, 1'b0, 32'd0);
		// Only the low byte of the data is stored by a one byte write.
		send_op(KIND_WRITE, 16'd0, WCODE_BYTE, 1'b0, 32'hFFFF_FFFF);
		send_op(KIND_READ, 16'd0, WCODE_BYTE, 1'b0, 32'd0);
		send_op(KIND_READ, 16'd0, WCODE_HALF, 1'b0, 32'd0);
		// Unaligned accesses in both byte orders.
		send_op(KIND_WRITE, 16'd1, WCODE_HALF, 1'b0, 32'h1234_BEEF);
		send_op(KIND_READ, 16'd1, WCODE_HALF, 1'b1, 32'd0);
		send_op(KIND_WRITE, 16'd5, WCODE_WORD, 1'b1, 32'hDEAD_BEEF);
		send_op(KIND_READ, 16'd5, WCODE_WORD, 1'b0, 32'd0);
		send_op(KIND_READ, 16'd5, WCODE_WORD, 1'b1, 32'd0);
		// The last bytes of the store and just past them.
		send_op(KIND_WRITE, 16'd2044, WCODE_WORD, 1'b0, 32'h0102_0304);
		send_op(KIND_READ, 16'd2044, WCODE_WORD, 1'b1, 32'd0);
		send_op(KIND_READ, 16'd2045, WCODE_WORD, 1'b0, 32'd0);
		send_op(KIND_WRITE, 16'd2047, WCODE_HALF, 1'b1, 32'hFFFF_FFFF);
		send_op(KIND_READ, 16'd2047, WCODE_BYTE, 1'b0, 32'd0);
		send_op(KIND_READ, 16'd2048, WCODE_BYTE, 1'b0, 32'd0);
		send_op(KIND_READ, 16'hFFFF, WCODE_BYTE, 1'b1, 32'd0);
		send_op(KIND_READ, 16'hFFFC, WCODE_WORD, 1'b0, 32'd0);
		// The reserved width fails and must leave the store alone.
		send_op(KIND_READ, 16'd0, WCODE_RSVD, 1'b0, 32'd0);
		send_op(KIND_WRITE, 16'd0, WCODE_RSVD, 1'b0, 32'h0000_0000);
		send_op(KIND_READ, 16'd0, WCODE_WORD, 1'b0, 32'd0);
		// The unused kind does nothing and raises no error.
		send_op(KIND_NONE, 16'hFFFF, WCODE_RSVD, 1'b1, 32'hFFFF_FFFF);
		send_op(KIND_CLEAR, 16'd0, WCODE_BYTE, 1'b0, 32'hFFFF_FF00);
		send_op(KIND_READ, 16'd2044, WCODE_WORD, 1'b1, 32'd0);

		// Random phases, each with its own size in use; the last has no idling.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			if (p == PHASE_COUNT - 1)
				quiet <= 1'b1;
			set_mem_size(phase_sizes[p]);
			repeat (PHASE_WORDS) random_op();
		end

		settle();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
